>>> rtl/core/lca_lift_pkg.sv
// lca_lift_pkg: sizes, datapath operation codes and status type for the
// binary-lifting ancestor engine; used by every module of the block but lca_lift_ram
package lca_lift_pkg;

    localparam int NODE_W      = 10;
    localparam int LEVEL_W     = 10;
    localparam int MAX_NODES   = 1024;
    localparam int LIFT_LEVELS = 11;
    localparam int IDX_W       = $clog2(LIFT_LEVELS);
    localparam int LVL_AW      = $clog2(MAX_NODES);
    localparam int ANC_DEPTH   = MAX_NODES * LIFT_LEVELS;
    localparam int ANC_AW      = $clog2(ANC_DEPTH);
    localparam int SUM_W       = ((LEVEL_W > LIFT_LEVELS - 1) ? LEVEL_W : LIFT_LEVELS - 1) + 1;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_ADD_LVL_RD,
        DP_ADD_WR0,
        DP_ADD_RD,
        DP_ADD_WR,
        DP_Q_RDA,
        DP_Q_RDB,
        DP_Q_SWAP,
        DP_IDX_DEC,
        DP_L_RD,
        DP_L_STEP,
        DP_L_LVL,
        DP_OUT_A,
        DP_P_INIT,
        DP_P_RDA,
        DP_P_RDB,
        DP_P_CMP,
        DP_F_RD,
        DP_F_OUT
    } t_dp_op;

    typedef struct packed {
        logic lift_ok;
        logic same;
        logic idx_zero;
        logic idx_last;
    } t_dp_stat;

    function automatic logic [ANC_AW-1:0] anc_addr(input logic [NODE_W-1:0] node,
                                                   input logic [IDX_W-1:0] k);
        return ANC_AW'(node) * ANC_AW'(LIFT_LEVELS) + ANC_AW'(k);
    endfunction

endpackage

>>> rtl/core/lca_lift_ram.sv
// lca_lift_ram: generic single-write, single-read ram with registered read
// standalone, no package dependency
module lca_lift_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/lca_lift_dp.sv
// lca_lift_dp: datapath with ancestor and level memories, node and level
// registers; depends on lca_lift_pkg and lca_lift_ram
module lca_lift_dp
    import lca_lift_pkg::*;
(
    input  logic              i_clk,
    input  t_dp_op            i_op,
    input  logic [NODE_W-1:0] i_node,
    input  logic [NODE_W-1:0] i_other_node,
    output t_dp_stat          o_stat,
    output logic [NODE_W-1:0] o_ancestor
);

    logic [NODE_W-1:0]  r_a;
    logic [NODE_W-1:0]  r_b;
    logic [NODE_W-1:0]  r_mid;
    logic [NODE_W-1:0]  r_pa;
    logic [NODE_W-1:0]  r_anc;
    logic [LEVEL_W-1:0] r_la;
    logic [LEVEL_W-1:0] r_lb;
    logic [IDX_W-1:0]   r_idx;

    logic               anc_we;
    logic [ANC_AW-1:0]  anc_waddr;
    logic [NODE_W-1:0]  anc_wdata;
    logic [ANC_AW-1:0]  anc_raddr;
    logic [NODE_W-1:0]  anc_rdata;
    logic               lvl_we;
    logic [LEVEL_W-1:0] lvl_wdata;
    logic [LVL_AW-1:0]  lvl_raddr;
    logic [LEVEL_W-1:0] lvl_rdata;
    logic [LEVEL_W-1:0] lvl_inc;
    logic [SUM_W-1:0]   lift_reach;

    lca_lift_ram #(.WIDTH(NODE_W), .DEPTH(ANC_DEPTH)) u_anc_ram (
        .i_clk   (i_clk),
        .i_we    (anc_we),
        .i_waddr (anc_waddr),
        .i_wdata (anc_wdata),
        .i_raddr (anc_raddr),
        .o_rdata (anc_rdata)
    );

    lca_lift_ram #(.WIDTH(LEVEL_W), .DEPTH(MAX_NODES)) u_lvl_ram (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (LVL_AW'(r_a)),
        .i_wdata (lvl_wdata),
        .i_raddr (lvl_raddr),
        .o_rdata (lvl_rdata)
    );

    // parent level plus one, saturating
    assign lvl_inc   = (lvl_rdata == {LEVEL_W{1'b1}}) ? lvl_rdata : lvl_rdata + LEVEL_W'(1);
    assign lvl_wdata = (r_a == r_b) ? '0 : lvl_inc;
    assign lvl_we    = (i_op == DP_ADD_WR0);

    always_comb begin
        anc_we    = 1'b0;
        anc_waddr = anc_addr(r_a, r_idx + IDX_W'(1));
        anc_wdata = anc_rdata;
        anc_raddr = anc_addr(r_a, r_idx);
        lvl_raddr = LVL_AW'(r_a);
        case (i_op)
            DP_ADD_LVL_RD: lvl_raddr = LVL_AW'(r_b);
            DP_ADD_WR0: begin
                anc_we    = 1'b1;
                anc_waddr = anc_addr(r_a, '0);
                anc_wdata = r_b;
            end
            DP_ADD_RD:     anc_raddr = anc_addr(r_mid, r_idx);
            DP_ADD_WR:     anc_we    = 1'b1;
            DP_Q_RDB:      lvl_raddr = LVL_AW'(r_b);
            DP_L_STEP:     lvl_raddr = LVL_AW'(anc_rdata);
            DP_P_RDB:      anc_raddr = anc_addr(r_b, r_idx);
            // parent of the node as it stands after this compare
            DP_P_CMP:      anc_raddr = anc_addr((r_pa != anc_rdata) ? r_pa : r_a, '0);
            DP_F_RD:       anc_raddr = anc_addr(r_a, '0);
            default: begin
            end
        endcase
    end

    assign lift_reach       = SUM_W'(r_lb) + (SUM_W'(1) << r_idx);
    assign o_stat.lift_ok   = SUM_W'(r_la) >= lift_reach;
    assign o_stat.same      = (r_a == r_b);
    assign o_stat.idx_zero  = (r_idx == '0);
    assign o_stat.idx_last  = (r_idx == IDX_W'(LIFT_LEVELS - 2));

    always_ff @(posedge i_clk) begin
        case (i_op)
            DP_LOAD: begin
                r_a <= i_node;
                r_b <= i_other_node;
            end
            DP_ADD_WR0: begin
                r_mid <= r_b;
                r_idx <= '0;
            end
            DP_ADD_WR: begin
                r_mid <= anc_rdata;
                r_idx <= r_idx + IDX_W'(1);
            end
            DP_Q_RDB:   r_la <= lvl_rdata;
            DP_Q_SWAP: begin
                r_idx <= IDX_W'(LIFT_LEVELS - 1);
                if (lvl_rdata > r_la) begin
                    r_a  <= r_b;
                    r_b  <= r_a;
                    r_la <= lvl_rdata;
                    r_lb <= r_la;
                end else begin
                    r_lb <= lvl_rdata;
                end
            end
            DP_IDX_DEC: r_idx <= r_idx - IDX_W'(1);
            DP_L_STEP:  r_a <= anc_rdata;
            DP_L_LVL: begin
                r_la  <= lvl_rdata;
                r_idx <= r_idx - IDX_W'(1);
            end
            DP_OUT_A:   r_anc <= r_a;
            DP_P_INIT:  r_idx <= IDX_W'(LIFT_LEVELS - 1);
            DP_P_RDB:   r_pa <= anc_rdata;
            DP_P_CMP: begin
                r_idx <= r_idx - IDX_W'(1);
                if (r_pa != anc_rdata) begin
                    r_a <= r_pa;
                    r_b <= anc_rdata;
                end
            end
            DP_F_OUT:   r_anc <= anc_rdata;
            default: begin
            end
        endcase
    end

    assign o_ancestor = r_anc;

endmodule

>>> rtl/core/lca_lift_ctrl.sv
// lca_lift_ctrl: sequencer for add and query words, drives datapath ops
// depends on lca_lift_pkg
module lca_lift_ctrl
    import lca_lift_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_cmd,
    input  t_dp_stat i_stat,
    output t_dp_op   o_op,
    output logic     o_busy,
    output logic     o_valid
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_LVL,
        ST_ADD_WR0,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_Q_RDA,
        ST_Q_RDB,
        ST_Q_SWAP,
        ST_L_CHK,
        ST_L_STEP,
        ST_L_LVL,
        ST_Q_CMP,
        ST_P_RDA,
        ST_P_RDB,
        ST_P_CMP,
        ST_F_RD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;
    t_dp_op op;

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        op      = DP_NOP;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    op      = DP_LOAD;
                    n_state = i_cmd ? ST_Q_RDA : ST_ADD_LVL;
                end
            end
            ST_ADD_LVL: begin
                op      = DP_ADD_LVL_RD;
                n_state = ST_ADD_WR0;
            end
            ST_ADD_WR0: begin
                op      = DP_ADD_WR0;
                n_state = ST_ADD_RD;
            end
            ST_ADD_RD: begin
                op      = DP_ADD_RD;
                n_state = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                op      = DP_ADD_WR;
                n_state = i_stat.idx_last ? ST_IDLE : ST_ADD_RD;
            end
            ST_Q_RDA: begin
                op      = DP_Q_RDA;
                n_state = ST_Q_RDB;
            end
            ST_Q_RDB: begin
                op      = DP_Q_RDB;
                n_state = ST_Q_SWAP;
            end
            ST_Q_SWAP: begin
                op      = DP_Q_SWAP;
                n_state = ST_L_CHK;
            end
            ST_L_CHK: begin
                if (i_stat.lift_ok) begin
                    op      = DP_L_RD;
                    n_state = ST_L_STEP;
                end else begin
                    op      = DP_IDX_DEC;
                    n_state = i_stat.idx_zero ? ST_Q_CMP : ST_L_CHK;
                end
            end
            ST_L_STEP: begin
                op      = DP_L_STEP;
                n_state = ST_L_LVL;
            end
            ST_L_LVL: begin
                op      = DP_L_LVL;
                n_state = i_stat.idx_zero ? ST_Q_CMP : ST_L_CHK;
            end
            ST_Q_CMP: begin
                if (i_stat.same) begin
                    op      = DP_OUT_A;
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    op      = DP_P_INIT;
                    n_state = ST_P_RDA;
                end
            end
            ST_P_RDA: begin
                op      = DP_P_RDA;
                n_state = ST_P_RDB;
            end
            ST_P_RDB: begin
                op      = DP_P_RDB;
                n_state = ST_P_CMP;
            end
            ST_P_CMP: begin
                op      = DP_P_CMP;
                n_state = i_stat.idx_zero ? ST_F_RD : ST_P_RDA;
            end
            ST_F_RD: begin
                op      = DP_F_OUT;
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // final read address is issued one state early, see below
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // parent of the last lifted node is read while leaving the second pass
    assign o_op    = (r_state == ST_P_CMP && i_stat.idx_zero) ? DP_P_CMP : op;
    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;

endmodule

>>> rtl/core/lowest_common_ancestor_lifting_unit.sv
// lowest_common_ancestor_lifting_unit: top level of the binary-lifting ancestor engine
// depends on lca_lift_pkg, lca_lift_ctrl, lca_lift_dp, lca_lift_ram
//
// usage
//   a word is taken when start is high and busy is low; i_cmd low adds
//   i_node with parent i_other_node (a node that is its own parent is a root),
//   i_cmd high asks for the lowest common ancestor of i_node and i_other_node
//   nodes must be added parent-first; an add gives no result
//   a query result appears on o_ancestor for one cycle with o_valid high;
//   the receiver cannot stall, so the result is simply presented once
//   add: parent entry and level written, then one ancestor memory read and write
//   per further lifting level; query: a taken lift reads the ancestor, then the
//   level of the new node; a skipped level only steps the index; each level of
//   the second pass reads both ancestors over the single read port of the ancestor memory, plus the final parent read
//   busy drops in the cycle o_valid rises, so the next word may follow at once
//   reset clears only the sequencer; the memories hold unknown data until written
//   ancestor memory: 1024 x 11 entries of 10 bits, level memory: 1024 x 10 bits
module lowest_common_ancestor_lifting_unit
    import lca_lift_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cmd,
    input  logic [NODE_W-1:0] i_node,
    input  logic [NODE_W-1:0] i_other_node,
    output logic              o_valid,
    output logic [NODE_W-1:0] o_ancestor
);

    t_dp_op   op;
    t_dp_stat stat;

    lca_lift_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_stat  (stat),
        .o_op    (op),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    lca_lift_dp u_dp (
        .i_clk        (i_clk),
        .i_op         (op),
        .i_node       (i_node),
        .i_other_node (i_other_node),
        .o_stat       (stat),
        .o_ancestor   (o_ancestor)
    );

endmodule
